// ===== sv/vrrq_pkg.sv =====
package vrrq_pkg;

    // default sizing of the ring
    localparam int RING_BYTES_DEF = 1024;
    localparam int LEN_BYTES_DEF  = 4;
    localparam int MAX_READ_DEF   = 64;

    // fixed field widths
    localparam int OP_W   = 3;
    localparam int BYTE_W = 8;
    localparam int LEN_W  = 11;
    localparam int STAT_W = 2;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_BEGIN = 3'd0,
        OP_PUSH_BYTE  = 3'd1,
        OP_POP        = 3'd2,
        OP_PEEK       = 3'd3,
        OP_CLEAR      = 3'd4
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_IGNORED = 2'd3
    } t_status;

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_PFX_WR  = 8'b0000_0010,
        S_TAIL    = 8'b0000_0100,
        S_BYTE_WR = 8'b0000_1000,
        S_PFX_RD  = 8'b0001_0000,
        S_CALC    = 8'b0010_0000,
        S_HEAD    = 8'b0100_0000,
        S_STREAM  = 8'b1000_0000
    } t_state;

endpackage

// ===== sv/variable_record_ring_queue.sv =====
// Byte ring queue of RING_BYTES bytes holding variable-length records, each a
// LEN_BYTES little-endian length prefix followed by its payload. A command is
// taken when start is high and busy is low; busy then stays high until the
// command's last result is on the outputs, and in that cycle the next command
// may already be taken. Results come on o_strobe, one per cycle, and cannot be
// held off. Every ring access goes through one memory port and one shared
// modulo index adder, one byte per cycle: push_begin writes the prefix and
// moves the tail, push_byte writes a payload byte, peek reads the prefix and
// streams up to MAX_READ bytes, pop also moves the head; clear and refused
// commands answer from idle. The ring needs no clearing after reset.
module variable_record_ring_queue
    import vrrq_pkg::*;
#(
    parameter int RING_BYTES = RING_BYTES_DEF,
    parameter int LEN_BYTES  = LEN_BYTES_DEF,
    parameter int MAX_READ   = MAX_READ_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [OP_W-1:0]   i_op,
    input  logic [BYTE_W-1:0] i_data_byte,
    input  logic [LEN_W-1:0]  i_length,
    output logic              o_strobe,
    output logic [STAT_W-1:0] o_status,
    output logic [BYTE_W-1:0] o_out_byte,
    output logic              o_byte_valid,
    output logic              o_last,
    output logic [LEN_W-1:0]  o_stored_length,
    output logic [LEN_W-1:0]  o_free_space,
    output logic              o_is_empty
);

    localparam int IW   = $clog2(RING_BYTES);
    localparam int FW   = $clog2(RING_BYTES + 1);
    localparam int LW   = 8 * LEN_BYTES;
    localparam int NW   = $clog2(MAX_READ + 1);
    localparam int CMAX = (MAX_READ > LEN_BYTES) ? MAX_READ : LEN_BYTES;
    localparam int CW   = $clog2(CMAX + 1);

    t_state            r_state, n_state;
    logic [IW-1:0]     r_head, n_head;
    logic [IW-1:0]     r_tail, n_tail;
    logic [FW-1:0]     r_free, n_free;
    logic [FW-1:0]     r_open, n_open;
    logic              r_pop, n_pop;
    logic [BYTE_W-1:0] r_db, n_db;
    logic [LEN_W-1:0]  r_len, n_len;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic [LW-1:0]     r_stored, n_stored;
    logic [IW-1:0]     r_pos, n_pos;
    logic [NW-1:0]     r_n, n_n;
    logic [FW-1:0]     r_skip, n_skip;

    logic              r_strobe, n_strobe;
    t_status           r_status, n_status;
    logic [BYTE_W-1:0] r_out_byte, n_out_byte;
    logic              r_byte_valid, n_byte_valid;
    logic              r_last, n_last;
    logic [LEN_W-1:0]  r_res_len, n_res_len;

    // shared index adder and memory port
    logic [IW-1:0]     wr_base;
    logic [FW-1:0]     wr_ofs;
    logic [IW-1:0]     wr_idx;
    logic              mem_we;
    logic              mem_re;
    logic [BYTE_W-1:0] mem_wdata;
    logic [BYTE_W-1:0] mem_rdata;

    vrrq_wrap #(
        .RING_BYTES(RING_BYTES)
    ) u_wrap (
        .i_base(wr_base),
        .i_ofs (wr_ofs),
        .o_idx (wr_idx)
    );

    vrrq_ram #(
        .WIDTH(BYTE_W),
        .DEPTH(RING_BYTES)
    ) u_ring (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(wr_idx),
        .i_wdata(mem_wdata),
        .i_re   (mem_re),
        .i_raddr(wr_idx),
        .o_rdata(mem_rdata)
    );

    always_comb begin
        logic [31:0] len32;
        logic [31:0] st32;
        logic [31:0] mn32;
        logic [FW:0] fsum;
        logic [FW-1:0] occ;
        logic [FW-1:0] skp;
        logic          too_wide;

        n_state      = r_state;
        n_head       = r_head;
        n_tail       = r_tail;
        n_free       = r_free;
        n_open       = r_open;
        n_pop        = r_pop;
        n_db         = r_db;
        n_len        = r_len;
        n_cnt        = r_cnt;
        n_stored     = r_stored;
        n_pos        = r_pos;
        n_n          = r_n;
        n_skip       = r_skip;
        n_strobe     = 1'b0;
        n_status     = r_status;
        n_out_byte   = r_out_byte;
        n_byte_valid = r_byte_valid;
        n_last       = r_last;
        n_res_len    = r_res_len;

        wr_base   = r_tail;
        wr_ofs    = '0;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_wdata = r_db;

        len32    = 32'(r_len);
        st32     = 32'(r_stored);
        mn32     = '0;
        fsum     = '0;
        occ      = '0;
        skp      = '0;
        too_wide = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_db         = i_data_byte;
                    n_len        = i_length;
                    n_cnt        = '0;
                    n_out_byte   = '0;
                    n_byte_valid = 1'b0;
                    n_last       = 1'b1;
                    n_res_len    = '0;
                    n_status     = ST_OK;
                    unique case (t_op'(i_op))
                        OP_PUSH_BEGIN: begin
                            too_wide = (64'(i_length) >> LW) != 64'd0;
                            if (too_wide || 32'(i_length) + 32'(LEN_BYTES) > 32'(r_free)) begin
                                n_status = ST_FULL;
                                n_strobe = 1'b1;
                            end else begin
                                n_state = S_PFX_WR;
                            end
                        end
                        OP_PUSH_BYTE: begin
                            if (r_open == '0) begin
                                n_status = ST_IGNORED;
                                n_strobe = 1'b1;
                            end else begin
                                n_state = S_BYTE_WR;
                            end
                        end
                        OP_POP, OP_PEEK: begin
                            n_pop = (t_op'(i_op) == OP_POP);
                            if (r_free >= FW'(RING_BYTES)) begin
                                n_status = ST_EMPTY;
                                n_strobe = 1'b1;
                            end else begin
                                n_state = S_PFX_RD;
                            end
                        end
                        OP_CLEAR: begin
                            n_tail   = r_head;
                            n_free   = FW'(RING_BYTES);
                            n_open   = '0;
                            n_strobe = 1'b1;
                        end
                        default: begin
                            n_status = ST_IGNORED;
                            n_strobe = 1'b1;
                        end
                    endcase
                end
            end
            S_PFX_WR: begin
                wr_base   = r_tail;
                wr_ofs    = FW'(r_cnt);
                mem_we    = 1'b1;
                mem_wdata = BYTE_W'(32'(r_len) >> {r_cnt, 3'b000});
                n_cnt     = r_cnt + 1'b1;
                if (r_cnt == CW'(LEN_BYTES - 1)) begin
                    n_state = S_TAIL;
                end
            end
            S_TAIL: begin
                wr_base  = r_tail;
                wr_ofs   = FW'(r_len) + FW'(LEN_BYTES);
                n_tail   = wr_idx;
                n_free   = r_free - wr_ofs;
                n_open   = FW'(r_len);
                n_strobe = 1'b1;
                n_state  = S_IDLE;
            end
            S_BYTE_WR: begin
                // next payload byte sits open_remaining bytes before the tail
                wr_base   = r_tail;
                wr_ofs    = FW'(RING_BYTES) - r_open;
                mem_we    = 1'b1;
                mem_wdata = r_db;
                n_open    = r_open - 1'b1;
                n_strobe  = 1'b1;
                n_state   = S_IDLE;
            end
            S_PFX_RD: begin
                wr_base = r_head;
                wr_ofs  = FW'(r_cnt);
                mem_re  = (r_cnt < CW'(LEN_BYTES));
                if (r_cnt != '0) begin
                    n_stored = (r_stored >> 8) | (LW'(mem_rdata) << (LW - 8));
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CW'(LEN_BYTES)) begin
                    n_state = S_CALC;
                end
            end
            S_CALC: begin
                wr_base = r_head;
                wr_ofs  = FW'(LEN_BYTES);
                n_pos   = wr_idx;
                mn32    = (len32 < st32) ? len32 : st32;
                if (mn32 > 32'(MAX_READ)) begin
                    mn32 = 32'(MAX_READ);
                end
                n_n = NW'(mn32);
                occ = FW'(RING_BYTES) - r_free;
                skp = (occ > FW'(LEN_BYTES)) ? occ - FW'(LEN_BYTES) : '0;
                if (st32 < 32'(skp)) begin
                    skp = FW'(r_stored);
                end
                n_skip  = skp;
                n_cnt   = '0;
                n_state = r_pop ? S_HEAD : S_STREAM;
            end
            S_HEAD: begin
                wr_base = r_head;
                wr_ofs  = FW'(LEN_BYTES) + r_skip;
                n_head  = wr_idx;
                fsum    = (FW+1)'(r_free) + (FW+1)'(LEN_BYTES) + (FW+1)'(r_skip);
                if (fsum >= (FW+1)'(RING_BYTES)) begin
                    n_free = FW'(RING_BYTES);
                    n_open = '0;
                end else begin
                    n_free = FW'(fsum);
                end
                n_state = S_STREAM;
            end
            S_STREAM: begin
                wr_base   = r_pos;
                wr_ofs    = FW'(r_cnt);
                n_status  = ST_OK;
                n_res_len = LEN_W'(r_stored);
                if (r_n == '0) begin
                    n_out_byte   = '0;
                    n_byte_valid = 1'b0;
                    n_last       = 1'b1;
                    n_strobe     = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    mem_re = (r_cnt < CW'(r_n));
                    n_cnt  = r_cnt + 1'b1;
                    // read data arrives in the cycle after its address is given
                    if (r_cnt != '0) begin
                        n_out_byte   = mem_rdata;
                        n_byte_valid = 1'b1;
                        n_last       = (r_cnt == CW'(r_n));
                        n_strobe     = 1'b1;
                    end
                    if (r_cnt == CW'(r_n)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_head   <= '0;
            r_tail   <= '0;
            r_free   <= FW'(RING_BYTES);
            r_open   <= '0;
            r_cnt    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_free   <= n_free;
            r_open   <= n_open;
            r_cnt    <= n_cnt;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pop        <= n_pop;
        r_db         <= n_db;
        r_len        <= n_len;
        r_stored     <= n_stored;
        r_pos        <= n_pos;
        r_n          <= n_n;
        r_skip       <= n_skip;
        r_status     <= n_status;
        r_out_byte   <= n_out_byte;
        r_byte_valid <= n_byte_valid;
        r_last       <= n_last;
        r_res_len    <= n_res_len;
    end

    assign busy            = (r_state != S_IDLE);
    assign o_strobe        = r_strobe;
    assign o_status        = r_status;
    assign o_out_byte      = r_out_byte;
    assign o_byte_valid    = r_byte_valid;
    assign o_last          = r_last;
    assign o_stored_length = r_res_len;
    assign o_free_space    = LEN_W'(r_free);
    assign o_is_empty      = (r_free == FW'(RING_BYTES));

    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free <= FW'(RING_BYTES))
        else $error("free count above ring size");

    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_last |-> !busy)
        else $error("final result shown while still busy");

    a_mid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_last |-> busy)
        else $error("partial result shown after command ended");

    a_byte_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_byte_valid |-> o_status == ST_OK)
        else $error("payload byte with error status");

    a_open_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_is_empty |-> $past(r_state) != S_BYTE_WR || $past(r_open) == '0)
        else $error("byte written into an empty ring");

endmodule

// ===== sv/vrrq_ram.sv =====
module vrrq_ram
    import vrrq_pkg::*;
#(
    parameter int WIDTH = BYTE_W,
    parameter int DEPTH = RING_BYTES_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/vrrq_wrap.sv =====
module vrrq_wrap
    import vrrq_pkg::*;
#(
    parameter int RING_BYTES = RING_BYTES_DEF
) (
    input  logic [$clog2(RING_BYTES)-1:0]   i_base,
    input  logic [$clog2(RING_BYTES+1)-1:0] i_ofs,
    output logic [$clog2(RING_BYTES)-1:0]   o_idx
);

    localparam int IW = $clog2(RING_BYTES);
    localparam int FW = $clog2(RING_BYTES + 1);

    logic [FW:0] sum;

    // base is below the ring size and the offset at most the ring size
    always_comb begin
        sum = (FW+1)'(i_base) + (FW+1)'(i_ofs);
        if (sum >= (FW+1)'(RING_BYTES)) begin
            sum = sum - (FW+1)'(RING_BYTES);
        end
        o_idx = IW'(sum);
    end

endmodule

// ===== test/testbench.sv =====
module testbench;
    import vrrq_pkg::*;

    localparam int RING   = RING_BYTES_DEF;
    localparam int LEN    = LEN_BYTES_DEF;
    localparam int MAX_RD = MAX_READ_DEF;
    localparam int TIMEOUT_CYCLES = 400000;
    localparam int DRAIN_CYCLES   = 100;

    // codes the block answers with ignored
    localparam logic [OP_W-1:0] OP_UNKNOWN_LO = OP_CLEAR + 1;
    localparam logic [OP_W-1:0] OP_UNKNOWN_HI = '1;

    typedef struct {
        logic [OP_W-1:0]   op;
        logic [BYTE_W-1:0] data;
        logic [LEN_W-1:0]  len;
        int                gap;
        bit                drain;
    } ring_cmd_t;

    typedef struct packed {
        t_status           status;
        logic [BYTE_W-1:0] rd_byte;
        logic              rd_valid;
        logic              last;
        logic [LEN_W-1:0]  stored_len;
        logic [LEN_W-1:0]  free_len;
        logic              empty;
    } ring_result_t;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic [OP_W-1:0]   i_op = '0;
    logic [BYTE_W-1:0] i_data_byte = '0;
    logic [LEN_W-1:0]  i_length = '0;
    logic              o_strobe;
    logic [STAT_W-1:0] o_status;
    logic [BYTE_W-1:0] o_out_byte;
    logic              o_byte_valid;
    logic              o_last;
    logic [LEN_W-1:0]  o_stored_length;
    logic [LEN_W-1:0]  o_free_space;
    logic              o_is_empty;

    ring_cmd_t    cmd_backlog[$];
    ring_result_t pending_results[$];
    ring_cmd_t    cur;
    bit           loaded = 1'b0;
    bit           gaps_on = 1'b1;
    bit           drain_next = 1'b0;
    int           mismatches = 0;
    int           cycles = 0;

    // predicted ring contents and pointers
    logic [7:0] ring_img[RING];
    bit         ring_wr[RING];
    int         ring_head = 0;
    int         ring_tail = 0;
    int         ring_free = RING;
    int         ring_open = 0;

    variable_record_ring_queue dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_op           (i_op),
        .i_data_byte    (i_data_byte),
        .i_length       (i_length),
        .o_strobe       (o_strobe),
        .o_status       (o_status),
        .o_out_byte     (o_out_byte),
        .o_byte_valid   (o_byte_valid),
        .o_last         (o_last),
        .o_stored_length(o_stored_length),
        .o_free_space   (o_free_space),
        .o_is_empty     (o_is_empty)
    );

    always #5 i_clk = ~i_clk;

    function automatic void expect_result(t_status st, logic [7:0] b, logic v, logic l,
                                          logic [LEN_W-1:0] stored);
        ring_result_t r;
        r.status     = st;
        r.rd_byte    = b;
        r.rd_valid   = v;
        r.last       = l;
        r.stored_len = stored;
        r.free_len   = LEN_W'(ring_free);
        r.empty      = (ring_free == RING);
        pending_results.push_back(r);
    endfunction

    function automatic void ring_apply(ring_cmd_t c);
        logic [31:0] stored;
        int n;
        int occ;
        int skip;
        int pos;
        case (c.op)
            OP_PUSH_BEGIN: begin
                if (longint'(c.len) >= (longint'(1) << (8 * LEN)) ||
                    int'(c.len) + LEN > ring_free) begin
                    expect_result(ST_FULL, 0, 0, 1, 0);
                end else begin
                    for (int k = 0; k < LEN; k++) begin
                        ring_img[(ring_tail + k) % RING] = 8'(c.len >> (8 * k));
                        ring_wr[(ring_tail + k) % RING] = 1'b1;
                    end
                    ring_tail = (ring_tail + LEN + int'(c.len)) % RING;
                    ring_free -= LEN + int'(c.len);
                    ring_open = int'(c.len);
                    expect_result(ST_OK, 0, 0, 1, 0);
                end
            end
            OP_PUSH_BYTE: begin
                if (ring_open == 0) begin
                    expect_result(ST_IGNORED, 0, 0, 1, 0);
                end else begin
                    ring_img[(ring_tail + RING - ring_open) % RING] = c.data;
                    ring_wr[(ring_tail + RING - ring_open) % RING] = 1'b1;
                    ring_open--;
                    expect_result(ST_OK, 0, 0, 1, 0);
                end
            end
            OP_POP, OP_PEEK: begin
                if (ring_free >= RING) begin
                    expect_result(ST_EMPTY, 0, 0, 1, 0);
                end else begin
                    stored = '0;
                    for (int k = 0; k < LEN; k++)
                        stored |= 32'(ring_img[(ring_head + k) % RING]) << (8 * k);
                    pos = (ring_head + LEN) % RING;
                    n = (int'(c.len) < stored) ? int'(c.len) : int'(stored);
                    if (n > MAX_RD) n = MAX_RD;
                    occ = RING - ring_free;
                    skip = (occ > LEN) ? occ - LEN : 0;
                    // a damaged prefix never frees more than is occupied
                    if (stored < skip) skip = stored;
                    if (c.op == OP_POP) begin
                        ring_head = (ring_head + LEN + skip) % RING;
                        ring_free += LEN + skip;
                        if (ring_free > RING) ring_free = RING;
                        if (ring_free == RING) ring_open = 0;
                    end
                    if (n == 0) begin
                        expect_result(ST_OK, 0, 0, 1, LEN_W'(stored));
                    end else begin
                        for (int k = 0; k < n; k++)
                            expect_result(ST_OK, ring_img[(pos + k) % RING], 1, k + 1 == n,
                                          LEN_W'(stored));
                    end
                end
            end
            OP_CLEAR: begin
                ring_tail = ring_head;
                ring_free = RING;
                ring_open = 0;
                expect_result(ST_OK, 0, 0, 1, 0);
            end
            default: expect_result(ST_IGNORED, 0, 0, 1, 0);
        endcase
    endfunction

    task automatic queue_cmd(input int op, input int data, input int len);
        ring_cmd_t c;
        c.op    = OP_W'(op);
        c.data  = BYTE_W'(data);
        c.len   = LEN_W'(len);
        c.gap   = 0;
        c.drain = drain_next;
        drain_next = 1'b0;
        if (gaps_on && $urandom_range(0, 3) == 0) c.gap = $urandom_range(1, 18);
        cmd_backlog.push_back(c);
    endtask

    function automatic void field_check(string what, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            if (mismatches < 40)
                $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
            mismatches++;
        end
    endfunction

    // driver
    always @(posedge i_clk) begin : drive
        int avail;
        bit go;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                ring_apply(cur);
                loaded = 1'b0;
            end
            if (!loaded && cmd_backlog.size() != 0) begin
                cur = cmd_backlog.pop_front();
                loaded = 1'b1;
                // keep reads on bytes that have been written at least once
                if ((cur.op == OP_POP || cur.op == OP_PEEK) && ring_free < RING) begin
                    avail = 0;
                    while (avail < MAX_RD && ring_wr[(ring_head + LEN + avail) % RING])
                        avail++;
                    if (cur.len > avail) cur.len = LEN_W'(avail);
                end
            end
            go = start && busy;
            if (!go && loaded) begin
                if (cur.gap > 0)
                    cur.gap--;
                else if (!(cur.drain && pending_results.size() != 0))
                    go = 1'b1;
            end
            start <= go;
            if (loaded) begin
                i_op        <= cur.op;
                i_data_byte <= cur.data;
                i_length    <= cur.len;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin : check
        ring_result_t want;
        if (i_rst_n && o_strobe) begin
            if (pending_results.size() == 0) begin
                if (mismatches < 40)
                    $display("%0t: result with no transaction pending, expected none, got status %0d",
                             $time, o_status);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                field_check("status", want.status, o_status);
                field_check("out_byte", want.rd_byte, o_out_byte);
                field_check("byte_valid", want.rd_valid, o_byte_valid);
                field_check("last", want.last, o_last);
                field_check("stored_length", want.stored_len, o_stored_length);
                field_check("free_space", want.free_len, o_free_space);
                field_check("is_empty", want.empty, o_is_empty);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles == TIMEOUT_CYCLES) begin
            $display("variable_record_ring_queue: mismatch");
            $finish;
        end
    end

    initial begin : stimulus
        int pick;
        int sel;
        int fill;
        int len;

        // empty ring, stray byte, unknown codes
        queue_cmd(OP_POP, 0, MAX_RD);
        queue_cmd(OP_PEEK, 0, MAX_RD);
        queue_cmd(OP_PUSH_BYTE, 8'h5A, 0);
        queue_cmd(OP_UNKNOWN_LO, 0, 0);
        queue_cmd(OP_UNKNOWN_HI, 8'hFF, 2047);
        // short record, zero-length and unlimited reads
        queue_cmd(OP_PUSH_BEGIN, 0, 3);
        queue_cmd(OP_PUSH_BYTE, 8'h00, 0);
        queue_cmd(OP_PUSH_BYTE, 8'hFF, 0);
        queue_cmd(OP_PUSH_BYTE, 8'hA5, 0);
        queue_cmd(OP_PEEK, 0, 0);
        queue_cmd(OP_PEEK, 0, 2047);
        queue_cmd(OP_POP, 0, 1);
        // too long, exact fit, then nothing fits
        queue_cmd(OP_PUSH_BEGIN, 0, RING);
        queue_cmd(OP_PUSH_BEGIN, 0, RING - LEN);
        queue_cmd(OP_PUSH_BEGIN, 0, 0);
        queue_cmd(OP_POP, 0, MAX_RD);
        // move tail two bytes short of the end so the next prefix wraps
        queue_cmd(OP_PUSH_BEGIN, 0, RING - 13);
        queue_cmd(OP_POP, 0, 5);
        queue_cmd(OP_PUSH_BEGIN, 0, 2);
        queue_cmd(OP_PUSH_BYTE, 8'h11, 0);
        // abandon the open record
        queue_cmd(OP_PUSH_BEGIN, 0, 1);
        queue_cmd(OP_PUSH_BYTE, 8'h22, 0);
        queue_cmd(OP_PEEK, 0, MAX_RD);
        queue_cmd(OP_POP, 0, MAX_RD);
        queue_cmd(OP_CLEAR, 0, 0);
        queue_cmd(OP_POP, 0, MAX_RD);

        drain_next = 1'b1;
        while (cmd_backlog.size() < 330) begin
            if (cmd_backlog.size() > 270)
                gaps_on = 1'b0;
            else if ($urandom_range(0, 29) == 0)
                gaps_on = !gaps_on;
            if ($urandom_range(0, 39) == 0) drain_next = 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                sel = $urandom_range(0, 19);
                if (sel < 14)
                    len = $urandom_range(0, 12);
                else if (sel < 18)
                    len = $urandom_range(13, 64);
                else
                    len = $urandom_range(65, RING);
                queue_cmd(OP_PUSH_BEGIN, $urandom, len);
                // long records stay mostly unwritten and push the tail around
                fill = (len > 64) ? $urandom_range(0, 8) : len;
                if ($urandom_range(0, 9) == 0) fill = $urandom_range(0, fill);
                for (int k = 0; k < fill; k++)
                    queue_cmd(OP_PUSH_BYTE, $urandom, $urandom);
            end else if (pick < 82) begin
                sel = $urandom_range(0, 9);
                if (sel < 4)
                    len = $urandom_range(MAX_RD, 2047);
                else if (sel < 8)
                    len = $urandom_range(0, 16);
                else
                    len = $urandom_range(0, 2047);
                queue_cmd((pick < 70) ? OP_POP : OP_PEEK, $urandom, len);
            end else if (pick < 86) begin
                queue_cmd(OP_CLEAR, $urandom, $urandom);
            end else begin
                sel = $urandom_range(0, 2);
                if (sel == 0)
                    queue_cmd(OP_PUSH_BYTE, $urandom, $urandom);
                else if (sel == 1)
                    queue_cmd($urandom_range(OP_UNKNOWN_LO, OP_UNKNOWN_HI), $urandom, $urandom);
                else
                    queue_cmd(OP_PUSH_BEGIN, $urandom, $urandom_range(1000, 2047));
            end
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (cmd_backlog.size() != 0 || loaded || pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0)
            $display("variable_record_ring_queue: match");
        else
            $display("variable_record_ring_queue: mismatch");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/vrrq_pkg.sv
sv/vrrq_ram.sv
sv/vrrq_wrap.sv
sv/variable_record_ring_queue.sv
test/testbench.sv
